[hw/rtl/okrs_pkg.sv]
// Shared types and constants for the ordered key set range-sum unit.
// No dependencies; imported by every module of the unit.
package okrs_pkg;

	localparam int CAPACITY_DEF  = 1024;
	localparam int KEY_WIDTH_DEF = 30;
	localparam int NEW_KEY_W     = 30;
	localparam int RANGE_W       = 30;
	localparam int TOTAL_W       = 40;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_QUERY  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_PRESENT  = 2'd1,
		ST_FULL     = 2'd2,
		ST_ANSWERED = 2'd3
	} status_t;

	// Control part of a request walking down the cell chain
	typedef struct packed {
		logic vld;
		op_t  op;
		logic found;
		logic placed;
	} req_ctl_t;

endpackage

[hw/rtl/okrs_cell.sv]
// One storage cell of the chain: holds one key slot and one request stage.
// Depends on okrs_pkg.
module okrs_cell #(
	parameter int KeyWidth = okrs_pkg::KEY_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           advance,
	input  okrs_pkg::req_ctl_t             ctl_in,
	input  logic [KeyWidth-1:0]            key_in,
	input  logic [okrs_pkg::RANGE_W-1:0]   low_in,
	input  logic [okrs_pkg::RANGE_W-1:0]   high_in,
	input  logic [okrs_pkg::TOTAL_W-1:0]   total_in,
	output okrs_pkg::req_ctl_t             ctl_out,
	output logic [KeyWidth-1:0]            key_out,
	output logic [okrs_pkg::RANGE_W-1:0]   low_out,
	output logic [okrs_pkg::RANGE_W-1:0]   high_out,
	output logic [okrs_pkg::TOTAL_W-1:0]   total_out,
	output logic                           slot_vld
);
	import okrs_pkg::*;

	localparam int CmpW = (KeyWidth > RANGE_W) ? KeyWidth : RANGE_W;
	localparam int SumW = TOTAL_W + 1;

	logic                slot_vld_q;
	logic [KeyWidth-1:0] slot_key_q;
	req_ctl_t            ctl_s1;
	logic [KeyWidth-1:0] key_s1;
	logic [RANGE_W-1:0]  low_s1;
	logic [RANGE_W-1:0]  high_s1;
	logic [TOTAL_W-1:0]  total_s1;

	logic                hit;
	logic                take;
	logic                in_rng;
	logic                add_en;
	logic [SumW-1:0]     sum_wide;
	logic [TOTAL_W-1:0]  total_nxt;
	req_ctl_t            ctl_nxt;

	// Compare the held key against the request
	assign hit    = slot_vld_q && (slot_key_q == key_in);
	assign take   = ctl_in.vld && (ctl_in.op == OP_INSERT) && !ctl_in.found
		&& !ctl_in.placed && !slot_vld_q;
	assign in_rng = (CmpW'(slot_key_q) >= CmpW'(low_in))
		&& (CmpW'(slot_key_q) <= CmpW'(high_in));
	assign add_en = (ctl_in.op == OP_QUERY) && slot_vld_q && in_rng;

	// Add this slot into the running total, saturating at all ones
	assign sum_wide  = SumW'(total_in) + (add_en ? SumW'(slot_key_q) : SumW'(0));
	assign total_nxt = sum_wide[TOTAL_W] ? {TOTAL_W{1'b1}} : sum_wide[TOTAL_W-1:0];

	always_comb begin
		ctl_nxt        = ctl_in;
		ctl_nxt.found  = ctl_in.found | ((ctl_in.op == OP_INSERT) && hit);
		ctl_nxt.placed = ctl_in.placed | take;
	end

	// Control state: slot valid bit and request stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= 1'b0;
			ctl_s1     <= '0;
		end else if (advance) begin
			slot_vld_q <= slot_vld_q | take;
			ctl_s1     <= ctl_nxt;
		end
	end

	// Payload: stored key and request fields handed to the next cell
	always_ff @(posedge clk) begin
		if (advance) begin
			key_s1   <= key_in;
			low_s1   <= low_in;
			high_s1  <= high_in;
			total_s1 <= total_nxt;
			if (take) begin
				slot_key_q <= key_in;
			end
		end
	end

	assign ctl_out   = ctl_s1;
	assign key_out   = key_s1;
	assign low_out   = low_s1;
	assign high_out  = high_s1;
	assign total_out = total_s1;
	assign slot_vld  = slot_vld_q;

	a_slot_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		slot_vld_q |=> slot_vld_q)
		else $error("filled slot lost its valid bit");

	a_slot_key_hold: assert property (@(posedge clk) disable iff (!arst_n)
		slot_vld_q |=> $stable(slot_key_q))
		else $error("filled slot key changed");

	a_query_no_mark: assert property (@(posedge clk) disable iff (!arst_n)
		advance && ctl_in.vld && (ctl_in.op == OP_QUERY) && !ctl_in.found
			&& !ctl_in.placed |=> !ctl_s1.found && !ctl_s1.placed)
		else $error("query request marked as insert outcome");

endmodule

[hw/rtl/okrs_result.sv]
// Result stage: decodes the chain tail into status and total, holds the response.
// Depends on okrs_pkg.
module okrs_result (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         rsp_ready,
	input  okrs_pkg::req_ctl_t           tail_ctl,
	input  logic [okrs_pkg::TOTAL_W-1:0] tail_total,
	output logic                         advance,
	output logic                         rsp_valid,
	output logic [1:0]                   status,
	output logic [okrs_pkg::TOTAL_W-1:0] range_total
);
	import okrs_pkg::*;

	logic               rsp_valid_q;
	status_t            status_q;
	logic [TOTAL_W-1:0] total_q;
	status_t            status_nxt;

	// Move the chain whenever the response register is free or being drained
	assign advance = !rsp_valid_q || rsp_ready;

	// Decode the insert outcome; queries always answer
	always_comb begin
		priority if (tail_ctl.op == OP_QUERY) begin
			status_nxt = ST_ANSWERED;
		end else if (tail_ctl.found) begin
			status_nxt = ST_PRESENT;
		end else if (tail_ctl.placed) begin
			status_nxt = ST_INSERTED;
		end else begin
			status_nxt = ST_FULL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= tail_ctl.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status_nxt;
			total_q  <= tail_total;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign range_total = total_q;

	a_insert_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (status_q != ST_ANSWERED) |-> (total_q == '0))
		else $error("insert response carries a nonzero total");

	a_query_status: assert property (@(posedge clk) disable iff (!arst_n)
		advance && tail_ctl.vld && (tail_ctl.op == OP_QUERY)
			|=> rsp_valid_q && (status_q == ST_ANSWERED))
		else $error("query response lost or misreported");

	a_tail_excl: assert property (@(posedge clk) disable iff (!arst_n)
		tail_ctl.vld |-> !(tail_ctl.found && tail_ctl.placed))
		else $error("insert both found and placed");

endmodule

[hw/rtl/ordered_key_set_range_sum_unit.sv]
// Top level of the ordered key set range-sum unit: cell chain plus result stage.
// Depends on okrs_pkg, okrs_cell and okrs_result.
//
// The unit stores up to CAPACITY distinct keys in a chain of cells, one key per
// cell, filled in order from cell 0; reset empties the store at once. Each
// request (insert or range query) walks the chain one cell per cycle while the
// chain advances, picking up the duplicate check, the free slot for an insert,
// and the running sum for a query. A new request is taken every cycle that the
// response register is free or being drained, so sustained throughput is one
// request per cycle, and each request passes through every cell and then the
// response register before its response appears. A stalled response freezes the whole chain.
module ordered_key_set_range_sum_unit #(
	parameter int CAPACITY  = okrs_pkg::CAPACITY_DEF,
	parameter int KEY_WIDTH = okrs_pkg::KEY_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic                           operation,
	input  logic [okrs_pkg::NEW_KEY_W-1:0] new_key,
	input  logic [okrs_pkg::RANGE_W-1:0]   range_low,
	input  logic [okrs_pkg::RANGE_W-1:0]   range_high,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output logic [1:0]                     status,
	output logic [okrs_pkg::TOTAL_W-1:0]   range_total
);
	import okrs_pkg::*;

	logic                advance;
	req_ctl_t            ctl_c   [CAPACITY+1];
	logic [KEY_WIDTH-1:0] key_c  [CAPACITY+1];
	logic [RANGE_W-1:0]  low_c   [CAPACITY+1];
	logic [RANGE_W-1:0]  high_c  [CAPACITY+1];
	logic [TOTAL_W-1:0]  total_c [CAPACITY+1];
	logic [CAPACITY-1:0] slot_vld;

	// Feed the chain head straight from the request ports
	assign ctl_c[0]   = '{vld: req_valid, op: op_t'(operation), found: 1'b0, placed: 1'b0};
	assign key_c[0]   = KEY_WIDTH'(new_key);
	assign low_c[0]   = range_low;
	assign high_c[0]  = range_high;
	assign total_c[0] = '0;
	assign req_ready  = advance;

	// Build the cell chain; the result stage reads only control and total at the tail
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		okrs_cell #(
			.KeyWidth (KEY_WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.advance   (advance),
			.ctl_in    (ctl_c[i]),
			.key_in    (key_c[i]),
			.low_in    (low_c[i]),
			.high_in   (high_c[i]),
			.total_in  (total_c[i]),
			.ctl_out   (ctl_c[i+1]),
			.key_out   (key_c[i+1]),
			.low_out   (low_c[i+1]),
			.high_out  (high_c[i+1]),
			.total_out (total_c[i+1]),
			.slot_vld  (slot_vld[i])
		);
	end

	okrs_result u_result (
		.clk         (clk),
		.arst_n      (arst_n),
		.rsp_ready   (rsp_ready),
		.tail_ctl    (ctl_c[CAPACITY]),
		.tail_total  (total_c[CAPACITY]),
		.advance     (advance),
		.rsp_valid   (rsp_valid),
		.status      (status),
		.range_total (range_total)
	);

	a_fill_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		(slot_vld & ~{slot_vld[CAPACITY-2:0], 1'b1}) == '0)
		else $error("filled slots do not form a prefix of the chain");

	a_tail_query_clean: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_c[CAPACITY].vld && (ctl_c[CAPACITY].op == OP_QUERY)
			|-> !ctl_c[CAPACITY].found && !ctl_c[CAPACITY].placed)
		else $error("query reached tail with insert marks");

	a_full_no_place: assert property (@(posedge clk) disable iff (!arst_n)
		(&slot_vld) && advance && ctl_c[0].vld |=> !ctl_c[1].placed)
		else $error("insert placed into a full store");

endmodule

[tb/tb.sv]
// Self-checking testbench for ordered_key_set_range_sum_unit: inserts and range-sum queries.
// Needs okrs_pkg and the unit's RTL. A mirror of the key set predicts every
// response, and the mirror's queue is checked in order against the unit.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import okrs_pkg::*;

	localparam int UNIT_CAPACITY = CAPACITY_DEF;
	localparam int UNIT_KEY_W    = KEY_WIDTH_DEF;
	localparam logic [NEW_KEY_W-1:0] KEY_MASK = NEW_KEY_W'((64'd1 << UNIT_KEY_W) - 64'd1);
	localparam logic [RANGE_W-1:0] BOUND_MAX = '1;
	localparam longint unsigned TOTAL_LIMIT = (64'd1 << TOTAL_W) - 64'd1;
	localparam int PHASE_ITEMS = 425;

	typedef struct {
		status_t              status;
		logic [TOTAL_W-1:0]   total;
	} outcome_t;

	// Mirror of the stored key set plus the queue of responses still owed
	class key_set_mirror;
		logic [NEW_KEY_W-1:0] stored_keys[$];
		bit                   is_stored[logic [NEW_KEY_W-1:0]];
		outcome_t             pending[$];
		int                   fault_count;

		function new();
			fault_count = 0;
		endfunction

		// Apply one accepted request and queue the response it must produce
		function void note_request(op_t op, logic [NEW_KEY_W-1:0] key,
				logic [RANGE_W-1:0] lo, logic [RANGE_W-1:0] hi);
			logic [NEW_KEY_W-1:0] cut_key;
			longint unsigned      acc;
			outcome_t             outcome;
			cut_key = key & KEY_MASK;
			outcome.total = '0;
			if (op == OP_QUERY) begin
				outcome.status = ST_ANSWERED;
				acc = 0;
				if (lo <= hi) begin
					foreach (stored_keys[i])
						if (stored_keys[i] >= lo && stored_keys[i] <= hi)
							acc += stored_keys[i];
				end
				outcome.total = (acc > TOTAL_LIMIT) ? TOTAL_LIMIT[TOTAL_W-1:0] : acc[TOTAL_W-1:0];
			end else if (is_stored.exists(cut_key)) begin
				outcome.status = ST_PRESENT;
			end else if (stored_keys.size() >= UNIT_CAPACITY) begin
				outcome.status = ST_FULL;
			end else begin
				stored_keys.push_back(cut_key);
				is_stored[cut_key] = 1'b1;
				outcome.status = ST_INSERTED;
			end
			pending.push_back(outcome);
		endfunction

		// Compare one response with the oldest owed outcome
		function void check_response(logic [1:0] st, logic [TOTAL_W-1:0] total);
			outcome_t want;
			if (pending.size() == 0) begin
				$error("response with no request pending: status %0d, range_total %0d",
					st, total);
				fault_count++;
				return;
			end
			want = pending.pop_front();
			if (st !== want.status) begin
				$error("status: expected %0d, actual %0d", want.status, st);
				fault_count++;
			end
			if (total !== want.total) begin
				$error("range_total: expected %0d, actual %0d", want.total, total);
				fault_count++;
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	logic                 operation = 1'b0;
	logic [NEW_KEY_W-1:0] new_key = '0;
	logic [RANGE_W-1:0]   range_low = '0;
	logic [RANGE_W-1:0]   range_high = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	logic [1:0]           status;
	logic [TOTAL_W-1:0]   range_total;

	int sender_idle_pct = 0;
	int recv_stall_pct = 0;
	key_set_mirror mirror = new();

	ordered_key_set_range_sum_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.operation   (operation),
		.new_key     (new_key),
		.range_low   (range_low),
		.range_high  (range_high),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.status      (status),
		.range_total (range_total)
	);

	always #6 clk = ~clk;

	// Stall the response side at random
	always @(posedge clk) begin
		rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Check every response taken
	always @(posedge clk) begin
		if (arst_n && rsp_valid === 1'b1 && rsp_ready)
			mirror.check_response(status, range_total);
	end

	// Offer one request after a random idle gap; hold it until taken
	task automatic send_request(input op_t op, input logic [NEW_KEY_W-1:0] key,
			input logic [RANGE_W-1:0] lo, input logic [RANGE_W-1:0] hi);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid  <= 1'b1;
		operation  <= op;
		new_key    <= key;
		range_low  <= lo;
		range_high <= hi;
		do @(posedge clk); while (req_ready !== 1'b1);
		mirror.note_request(op, key, lo, hi);
	endtask

	function automatic logic [NEW_KEY_W-1:0] random_word();
		logic [31:0] w;
		w = $urandom();
		return w[NEW_KEY_W-1:0];
	endfunction

	function automatic logic [NEW_KEY_W-1:0] any_stored_key();
		if (mirror.stored_keys.size() == 0)
			return random_word();
		return mirror.stored_keys[$urandom_range(mirror.stored_keys.size() - 1)];
	endfunction

	// Draw a key: mostly fresh, spread over the whole field, some repeats
	function automatic logic [NEW_KEY_W-1:0] pick_key();
		int r;
		r = $urandom_range(99);
		if (r < 10)
			return any_stored_key();
		if (r < 55)
			return random_word();
		if (r < 70)
			return NEW_KEY_W'($urandom_range(4095));
		if (r < 82)
			return BOUND_MAX - NEW_KEY_W'($urandom_range(4095));
		return (NEW_KEY_W'(1) << (NEW_KEY_W - 1)) ^ NEW_KEY_W'($urandom_range(65535));
	endfunction

	initial begin
		logic [RANGE_W-1:0] lo, hi, tmp, k, d;
		int r;
		// Hold reset, then release it once
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, duplicates, empty and single-point ranges
		send_request(OP_QUERY,  random_word(), '0, BOUND_MAX);
		send_request(OP_INSERT, '0, random_word(), random_word());
		send_request(OP_INSERT, BOUND_MAX, random_word(), random_word());
		send_request(OP_INSERT, '0, random_word(), random_word());
		send_request(OP_INSERT, BOUND_MAX, random_word(), random_word());
		send_request(OP_QUERY,  random_word(), '0, BOUND_MAX);
		send_request(OP_QUERY,  random_word(), BOUND_MAX, '0);
		send_request(OP_QUERY,  random_word(), '0, '0);
		send_request(OP_QUERY,  random_word(), BOUND_MAX, BOUND_MAX);
		send_request(OP_INSERT, 30'd1, '0, '0);
		send_request(OP_INSERT, 30'h2AAA_AAAA, BOUND_MAX, BOUND_MAX);
		send_request(OP_INSERT, 30'h1555_5555, '0, BOUND_MAX);
		send_request(OP_QUERY,  random_word(), 30'd1, BOUND_MAX - 30'd1);
		send_request(OP_QUERY,  random_word(), 30'h1555_5555, 30'h2AAA_AAAA);
		send_request(OP_QUERY,  random_word(), 30'h1555_5556, 30'h2AAA_AAA9);
		send_request(OP_QUERY,  random_word(), 30'd2, '0);
		send_request(OP_QUERY,  random_word(), 30'd1, 30'd1);
		send_request(OP_INSERT, 30'h1555_5555, random_word(), random_word());

		// Random: fill the store mostly with inserts, then lean toward queries
		for (int phase = 0; phase < 4; phase++) begin
			unique case (phase)
				0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin sender_idle_pct = 73; recv_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  recv_stall_pct = 73; end
				default: begin sender_idle_pct = 33; recv_stall_pct = 33; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				r = $urandom_range(99);
				if (r < ((mirror.stored_keys.size() < UNIT_CAPACITY) ? 88 : 35)) begin
					send_request(OP_INSERT, pick_key(), random_word(), random_word());
				end else begin
					r = $urandom_range(99);
					if (r < 25) begin
						lo = random_word();
						hi = random_word();
					end else if (r < 40) begin
						// empty range: low bound above high bound
						lo = random_word();
						hi = random_word();
						if (lo < hi) begin
							tmp = lo; lo = hi; hi = tmp;
						end
					end else if (r < 60) begin
						lo = any_stored_key();
						hi = any_stored_key();
						if (lo > hi) begin
							tmp = lo; lo = hi; hi = tmp;
						end
					end else if (r < 70) begin
						lo = any_stored_key();
						hi = lo;
					end else if (r < 80) begin
						lo = '0;
						hi = BOUND_MAX;
					end else begin
						// narrow window around a stored key
						k = any_stored_key();
						d = RANGE_W'($urandom_range(3));
						lo = (k > d) ? k - d : '0;
						hi = (k <= BOUND_MAX - d) ? k + d : BOUND_MAX;
					end
					send_request(OP_QUERY, random_word(), lo, hi);
				end
			end
		end
		req_valid <= 1'b0;

		// Drain, then let the chain settle before judging
		while (mirror.pending.size() != 0) @(posedge clk);
		repeat (UNIT_CAPACITY + 16) @(posedge clk);
		if (mirror.fault_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#30_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
